[design/vgm_pkg.sv]
package vgm_pkg;

	// Width of an internal chunk coordinate or extent; covers sizes up to 64.
	localparam int CW = 7;
	// Width of the running quad number.
	localparam int QW = 14;
	// Default chunk size along each axis.
	localparam int DEF_SIZE = 16;

	// Sweep axis value once all three axes are done.
	localparam logic [1:0] AXIS_DONE = 2'd3;

	// Operation codes carried by the mode field.
	typedef enum logic [1:0] {
		MODE_LOAD    = 2'd0,
		MODE_FETCH   = 2'd1,
		MODE_RESTART = 2'd2,
		MODE_NONE    = 2'd3
	} mode_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BUILD,
		ST_BTAIL,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_WID_RD,
		ST_WID_CHK,
		ST_GROW_RD,
		ST_GROW_CHK,
		ST_ZERO,
		ST_NEXT,
		ST_EMIT
	} state_t;

	// One result transaction.
	typedef struct packed {
		logic          valid_res;
		logic [1:0]    axis;
		logic [4:0]    base_x;
		logic [4:0]    base_y;
		logic [4:0]    base_z;
		logic [4:0]    span_u;
		logic [4:0]    span_v;
		logic [QW-1:0] quad_index;
	} res_t;

endpackage

[design/vgm_in_if.sv]
interface vgm_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [3:0] vox_x;
	logic [3:0] vox_y;
	logic [3:0] vox_z;
	logic       solid;

	modport source (output valid, mode, vox_x, vox_y, vox_z, solid, input ready);
	modport sink (input valid, mode, vox_x, vox_y, vox_z, solid, output ready);
endinterface

[design/vgm_out_if.sv]
interface vgm_out_if;
	logic        valid;
	logic        ready;
	logic        valid_res;
	logic [1:0]  axis;
	logic [4:0]  base_x;
	logic [4:0]  base_y;
	logic [4:0]  base_z;
	logic [4:0]  span_u;
	logic [4:0]  span_v;
	logic [13:0] quad_index;

	modport source (output valid, valid_res, axis, base_x, base_y, base_z, span_u, span_v,
		quad_index, input ready);
	modport sink (input valid, valid_res, axis, base_x, base_y, base_z, span_u, span_v,
		quad_index, output ready);
endinterface

[design/vgm_vox_ram.sv]
module vgm_vox_ram #(
	parameter int AW = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic [AW-1:0] ra_addr,
	input  logic [AW-1:0] rb_addr,
	output logic          ra_data,
	output logic          rb_data,
	output logic          busy
);

	localparam int DEPTH = 1 << AW;

	logic           mem [DEPTH];
	logic [AW-1:0]  clr_addr_q;
	logic           busy_q;
	logic           wr_en;
	logic [AW-1:0]  wr_addr;
	logic           wr_data;

	// After reset every entry is swept to empty before any other write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			busy_q     <= 1'b1;
		end else if (busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign wr_en   = busy_q | we;
	assign wr_addr = busy_q ? clr_addr_q : waddr;
	assign wr_data = busy_q ? 1'b0 : wdata;

	// One write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		ra_data <= mem[ra_addr];
		rb_data <= mem[rb_addr];
	end

	assign busy = busy_q;

endmodule

[design/vgm_mask_ram.sv]
module vgm_mask_ram #(
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic                     wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic                     rdata
);

	logic mem [DEPTH];

	// Face mask of the current slice, one bit per cell.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[design/vgm_ctrl.sv]
module vgm_ctrl import vgm_pkg::*; #(
	parameter int SIZE_X = DEF_SIZE,
	parameter int SIZE_Y = DEF_SIZE,
	parameter int SIZE_Z = DEF_SIZE,
	parameter int VAW    = 12,
	parameter int MDEPTH = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	vgm_in_if.sink                    req,
	vgm_out_if.source                 rsp,
	input  logic                      vox_busy,
	output logic                      vox_we,
	output logic [VAW-1:0]            vox_waddr,
	output logic                      vox_wdata,
	output logic [VAW-1:0]            vox_ra,
	output logic [VAW-1:0]            vox_rb,
	input  logic                      vox_da,
	input  logic                      vox_db,
	output logic                      mask_we,
	output logic [$clog2(MDEPTH)-1:0] mask_waddr,
	output logic                      mask_wdata,
	output logic [$clog2(MDEPTH)-1:0] mask_raddr,
	input  logic                      mask_rdata
);

	localparam int XW  = $clog2(SIZE_X);
	localparam int YW  = $clog2(SIZE_Y);
	localparam int ZW  = $clog2(SIZE_Z);
	localparam int MW  = $clog2(MDEPTH);
	localparam int MCW = $clog2(MDEPTH + 1);
	localparam logic [CW-1:0] SX = CW'(SIZE_X);
	localparam logic [CW-1:0] SY = CW'(SIZE_Y);
	localparam logic [CW-1:0] SZ = CW'(SIZE_Z);

	state_t         state_q, state_d;
	logic [1:0]     axis_q;
	logic [CW-1:0]  sp1_q;
	logic           mready_q;
	logic [MCW-1:0] scan_pos_q;
	logic [CW-1:0]  scan_i_q, scan_j_q;
	logic [CW-1:0]  bi_q, bj_q;
	logic [MCW-1:0] bk_q;
	logic [MCW-1:0] n_q, row_q;
	logic [CW-1:0]  qi_q, qj_q, w_q, h_q, a_q, b_q;
	logic [QW-1:0]  qcount_q;
	logic           done_q;
	logic           out_valid_q;
	res_t           res_q;
	logic           bvalid_s1, ina_s1, inb_s1;
	logic [MCW-1:0] bk_s1;

	logic           acc, fetch, load, restart;
	logic [CW-1:0]  dim_d, dim_u, dim_v;
	logic           bld_last, scan_end, wid_ok, grow_ok, zero_last, slice_wrap, emit_free;
	logic [CW-1:0]  wi_sum;
	logic [CW-1:0]  ax_x, ax_y, ax_z, bx_x, bx_y, bx_z;
	logic [CW-1:0]  lx, ly, lz;
	logic [CW-1:0]  bsx, bsy, bsz;
	logic [MCW-1:0] row_a;

	// Input transaction decode.
	assign req.ready = (state_q == ST_IDLE) && !vox_busy;
	assign acc       = req.valid && req.ready;
	assign fetch     = acc && (req.mode == MODE_FETCH);
	assign load      = acc && (req.mode == MODE_LOAD);
	assign restart   = acc && (req.mode == MODE_RESTART);

	// Plane extents for the current axis.
	always_comb begin
		unique case (axis_q)
			2'd0: begin
				dim_d = SX; dim_u = SY; dim_v = SZ;
			end
			2'd1: begin
				dim_d = SY; dim_u = SZ; dim_v = SX;
			end
			default: begin
				dim_d = SZ; dim_u = SX; dim_v = SY;
			end
		endcase
	end

	assign bld_last   = (bi_q == dim_u - 1'b1) && (bj_q == dim_v - 1'b1);
	assign scan_end   = (scan_j_q == dim_v);
	assign wi_sum     = qi_q + w_q;
	assign wid_ok     = wi_sum < dim_u;
	assign grow_ok    = (qj_q + h_q) < dim_v;
	assign zero_last  = (a_q == w_q - 1'b1) && (b_q == h_q - 1'b1);
	assign slice_wrap = (sp1_q >= dim_d);
	assign emit_free  = !out_valid_q || rsp.ready;
	assign row_a      = row_q + MCW'(a_q);

	// Voxel coordinates on both sides of the slice plane for the build cell.
	always_comb begin
		unique case (axis_q)
			2'd0: begin
				ax_x = sp1_q - 1'b1; ax_y = bi_q; ax_z = bj_q;
				bx_x = sp1_q;        bx_y = bi_q; bx_z = bj_q;
			end
			2'd1: begin
				ax_x = bj_q; ax_y = sp1_q - 1'b1; ax_z = bi_q;
				bx_x = bj_q; bx_y = sp1_q;        bx_z = bi_q;
			end
			default: begin
				ax_x = bi_q; ax_y = bj_q; ax_z = sp1_q - 1'b1;
				bx_x = bi_q; bx_y = bj_q; bx_z = sp1_q;
			end
		endcase
	end

	// Base corner of the current quad in x, y, z order.
	always_comb begin
		unique case (axis_q)
			2'd0: begin
				bsx = sp1_q; bsy = qi_q; bsz = qj_q;
			end
			2'd1: begin
				bsx = qj_q; bsy = sp1_q; bsz = qi_q;
			end
			default: begin
				bsx = qi_q; bsy = qj_q; bsz = sp1_q;
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (fetch) begin
					if (axis_q == AXIS_DONE) begin
						state_d = ST_EMIT;
					end else if (!mready_q) begin
						state_d = ST_BUILD;
					end else begin
						state_d = ST_SCAN_RD;
					end
				end
			end
			ST_BUILD:    state_d = bld_last ? ST_BTAIL : ST_BUILD;
			ST_BTAIL:    state_d = ST_SCAN_RD;
			ST_SCAN_RD:  state_d = scan_end ? ST_NEXT : ST_SCAN_CHK;
			ST_SCAN_CHK: state_d = mask_rdata ? ST_WID_RD : ST_SCAN_RD;
			ST_WID_RD:   state_d = wid_ok ? ST_WID_CHK : ST_GROW_RD;
			ST_WID_CHK:  state_d = mask_rdata ? ST_WID_RD : ST_GROW_RD;
			ST_GROW_RD:  state_d = grow_ok ? ST_GROW_CHK : ST_ZERO;
			ST_GROW_CHK: state_d = mask_rdata ? ST_GROW_RD : ST_ZERO;
			ST_ZERO:     state_d = zero_last ? ST_EMIT : ST_ZERO;
			ST_NEXT:     state_d = (slice_wrap && axis_q == 2'd2) ? ST_EMIT : ST_BUILD;
			ST_EMIT:     state_d = emit_free ? ST_IDLE : ST_EMIT;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Memory port controls.
	always_comb begin
		lx = {3'b000, req.vox_x};
		ly = {3'b000, req.vox_y};
		lz = {3'b000, req.vox_z};
		vox_we     = load && (lx < SX) && (ly < SY) && (lz < SZ);
		vox_waddr  = {lz[ZW-1:0], ly[YW-1:0], lx[XW-1:0]};
		vox_wdata  = req.solid;
		vox_ra     = {ax_z[ZW-1:0], ax_y[YW-1:0], ax_x[XW-1:0]};
		vox_rb     = {bx_z[ZW-1:0], bx_y[YW-1:0], bx_x[XW-1:0]};
		mask_we    = 1'b0;
		mask_waddr = bk_s1[MW-1:0];
		mask_wdata = (vox_da && ina_s1) != (vox_db && inb_s1);
		mask_raddr = scan_pos_q[MW-1:0];
		unique case (state_q)
			ST_BUILD, ST_BTAIL: begin
				mask_we = bvalid_s1;
			end
			ST_ZERO: begin
				mask_we    = 1'b1;
				mask_waddr = row_a[MW-1:0];
				mask_wdata = 1'b0;
			end
			ST_WID_RD: begin
				mask_raddr = MW'(n_q + MCW'(w_q));
			end
			ST_GROW_RD: begin
				mask_raddr = row_a[MW-1:0];
			end
			default: begin
			end
		endcase
	end

	// Build pipeline stage: voxel read data arrives in the cycle after the address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bvalid_s1 <= 1'b0;
		end else begin
			bvalid_s1 <= (state_q == ST_BUILD);
		end
	end

	always_ff @(posedge clk) begin
		bk_s1  <= bk_q;
		ina_s1 <= (sp1_q != '0);
		inb_s1 <= (sp1_q < dim_d);
	end

	// Sequencer and sweep registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			axis_q      <= '0;
			sp1_q       <= '0;
			mready_q    <= 1'b0;
			scan_pos_q  <= '0;
			scan_i_q    <= '0;
			scan_j_q    <= '0;
			qcount_q    <= '0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// A result that is taken is dropped unless a new one is loaded in its place.
			if (rsp.valid && rsp.ready && !(state_q == ST_EMIT && emit_free)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (restart) begin
						axis_q     <= '0;
						sp1_q      <= '0;
						mready_q   <= 1'b0;
						scan_pos_q <= '0;
						scan_i_q   <= '0;
						scan_j_q   <= '0;
						qcount_q   <= '0;
					end
					if (fetch) begin
						done_q <= (axis_q == AXIS_DONE);
					end
				end
				ST_BTAIL: begin
					mready_q   <= 1'b1;
					scan_pos_q <= '0;
					scan_i_q   <= '0;
					scan_j_q   <= '0;
				end
				ST_SCAN_CHK: begin
					if (!mask_rdata) begin
						scan_pos_q <= scan_pos_q + 1'b1;
						if (scan_i_q == dim_u - 1'b1) begin
							scan_i_q <= '0;
							scan_j_q <= scan_j_q + 1'b1;
						end else begin
							scan_i_q <= scan_i_q + 1'b1;
						end
					end
				end
				ST_ZERO: begin
					done_q <= 1'b0;
					if (zero_last) begin
						scan_pos_q <= n_q + MCW'(w_q);
						if (wi_sum == dim_u) begin
							scan_i_q <= '0;
							scan_j_q <= qj_q + 1'b1;
						end else begin
							scan_i_q <= wi_sum;
							scan_j_q <= qj_q;
						end
					end
				end
				ST_NEXT: begin
					mready_q   <= 1'b0;
					scan_pos_q <= '0;
					scan_i_q   <= '0;
					scan_j_q   <= '0;
					if (slice_wrap) begin
						sp1_q  <= '0;
						axis_q <= axis_q + 1'b1;
						done_q <= (axis_q == 2'd2);
					end else begin
						sp1_q <= sp1_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (emit_free) begin
						out_valid_q <= 1'b1;
						if (!done_q) begin
							qcount_q <= qcount_q + 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Quad working registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE, ST_NEXT: begin
				bi_q <= '0;
				bj_q <= '0;
				bk_q <= '0;
			end
			ST_BUILD: begin
				bk_q <= bk_q + 1'b1;
				if (bi_q == dim_u - 1'b1) begin
					bi_q <= '0;
					bj_q <= bj_q + 1'b1;
				end else begin
					bi_q <= bi_q + 1'b1;
				end
			end
			ST_SCAN_CHK: begin
				n_q  <= scan_pos_q;
				qi_q <= scan_i_q;
				qj_q <= scan_j_q;
				w_q  <= CW'(1);
			end
			ST_WID_RD: begin
				h_q   <= CW'(1);
				row_q <= n_q + MCW'(dim_u);
				a_q   <= '0;
			end
			ST_WID_CHK: begin
				if (mask_rdata) begin
					w_q <= w_q + 1'b1;
				end
				h_q   <= CW'(1);
				row_q <= n_q + MCW'(dim_u);
				a_q   <= '0;
			end
			ST_GROW_RD: begin
				if (!grow_ok) begin
					row_q <= n_q;
					a_q   <= '0;
					b_q   <= '0;
				end
			end
			ST_GROW_CHK: begin
				if (!mask_rdata) begin
					row_q <= n_q;
					a_q   <= '0;
					b_q   <= '0;
				end else if (a_q == w_q - 1'b1) begin
					h_q   <= h_q + 1'b1;
					row_q <= row_q + MCW'(dim_u);
					a_q   <= '0;
				end else begin
					a_q <= a_q + 1'b1;
				end
			end
			ST_ZERO: begin
				if (a_q == w_q - 1'b1) begin
					a_q   <= '0;
					b_q   <= b_q + 1'b1;
					row_q <= row_q + MCW'(dim_u);
				end else begin
					a_q <= a_q + 1'b1;
				end
			end
			ST_EMIT: begin
				if (emit_free) begin
					if (done_q) begin
						res_q <= '0;
					end else begin
						res_q.valid_res  <= 1'b1;
						res_q.axis       <= axis_q;
						res_q.base_x     <= bsx[4:0];
						res_q.base_y     <= bsy[4:0];
						res_q.base_z     <= bsz[4:0];
						res_q.span_u     <= w_q[4:0];
						res_q.span_v     <= h_q[4:0];
						res_q.quad_index <= qcount_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Output register drives the result channel.
	assign rsp.valid      = out_valid_q;
	assign rsp.valid_res  = res_q.valid_res;
	assign rsp.axis       = res_q.axis;
	assign rsp.base_x     = res_q.base_x;
	assign rsp.base_y     = res_q.base_y;
	assign rsp.base_z     = res_q.base_z;
	assign rsp.span_u     = res_q.span_u;
	assign rsp.span_v     = res_q.span_v;
	assign rsp.quad_index = res_q.quad_index;

endmodule

[design/voxel_greedy_mesher.sv]
// Greedy mesher for one voxel chunk. Load transactions write solid bits into an
// on-chip voxel memory; fetch transactions return the next merged quad of the sweep
// over axes x, y, z, or a result with valid_res low once the sweep is done; restart
// rewinds the sweep and keeps the chunk. A fetch walks the face mask memory, which has
// one write and one read port: it builds a slice mask over every plane cell, scans
// past empty cells, and for a found quad of w by h cells widens, grows and clears
// it. After reset the voxel memory is cleared one entry per cycle (2^(log2 SIZE_X +
// log2 SIZE_Y + log2 SIZE_Z) entries, 4096 by default) and no transaction is
// accepted until the pass ends.
module voxel_greedy_mesher import vgm_pkg::*; #(
	parameter int SIZE_X = DEF_SIZE,
	parameter int SIZE_Y = DEF_SIZE,
	parameter int SIZE_Z = DEF_SIZE
) (
	input logic       clk,
	input logic       arst_n,
	vgm_in_if.sink    req,
	vgm_out_if.source rsp
);

	localparam int VAW = $clog2(SIZE_X) + $clog2(SIZE_Y) + $clog2(SIZE_Z);
	localparam int PXY = SIZE_X * SIZE_Y;
	localparam int PYZ = SIZE_Y * SIZE_Z;
	localparam int PZX = SIZE_Z * SIZE_X;
	localparam int PM1 = (PXY > PYZ) ? PXY : PYZ;
	localparam int MDEPTH = (PM1 > PZX) ? PM1 : PZX;
	localparam int MW = $clog2(MDEPTH);

	logic           vox_busy, vox_we, vox_wdata, vox_da, vox_db;
	logic [VAW-1:0] vox_waddr, vox_ra, vox_rb;
	logic           mask_we, mask_wdata, mask_rdata;
	logic [MW-1:0]  mask_waddr, mask_raddr;

	vgm_vox_ram #(.AW(VAW)) u_vox (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (vox_we),
		.waddr   (vox_waddr),
		.wdata   (vox_wdata),
		.ra_addr (vox_ra),
		.rb_addr (vox_rb),
		.ra_data (vox_da),
		.rb_data (vox_db),
		.busy    (vox_busy)
	);

	vgm_mask_ram #(.DEPTH(MDEPTH)) u_mask (
		.clk   (clk),
		.we    (mask_we),
		.waddr (mask_waddr),
		.wdata (mask_wdata),
		.raddr (mask_raddr),
		.rdata (mask_rdata)
	);

	vgm_ctrl #(
		.SIZE_X (SIZE_X),
		.SIZE_Y (SIZE_Y),
		.SIZE_Z (SIZE_Z),
		.VAW    (VAW),
		.MDEPTH (MDEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.vox_busy   (vox_busy),
		.vox_we     (vox_we),
		.vox_waddr  (vox_waddr),
		.vox_wdata  (vox_wdata),
		.vox_ra     (vox_ra),
		.vox_rb     (vox_rb),
		.vox_da     (vox_da),
		.vox_db     (vox_db),
		.mask_we    (mask_we),
		.mask_waddr (mask_waddr),
		.mask_wdata (mask_wdata),
		.mask_raddr (mask_raddr),
		.mask_rdata (mask_rdata)
	);

endmodule

[design/vgm_checker.sv]
module vgm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        valid_res,
	input logic [1:0]  axis,
	input logic [4:0]  base_x,
	input logic [4:0]  base_y,
	input logic [4:0]  base_z,
	input logic [4:0]  span_u,
	input logic [4:0]  span_v,
	input logic [13:0] quad_index
);

	// A stalled result transaction stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable({valid_res, axis, base_x, base_y, base_z,
			span_u, span_v, quad_index}))
		else $error("result payload changed while stalled");

	// An end-of-sweep result carries all-zero fields.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !valid_res |-> (axis == 2'd0) && (base_x == 5'd0) && (base_y == 5'd0)
			&& (base_z == 5'd0) && (span_u == 5'd0) && (span_v == 5'd0)
			&& (quad_index == 14'd0))
		else $error("end-of-sweep result with nonzero fields");

	// A returned quad has a real axis and nonempty extents.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && valid_res |-> (axis != 2'd3) && (span_u != 5'd0) && (span_v != 5'd0))
		else $error("malformed quad");

endmodule

bind voxel_greedy_mesher vgm_checker u_vgm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.valid_res  (rsp.valid_res),
	.axis       (rsp.axis),
	.base_x     (rsp.base_x),
	.base_y     (rsp.base_y),
	.base_z     (rsp.base_z),
	.span_u     (rsp.span_u),
	.span_v     (rsp.span_v),
	.quad_index (rsp.quad_index)
);
